>>> sv/spa_pkg.sv
// Shared types, widths and constants for the spectrum power dB averager.
// No dependencies; compiled first.
package spa_pkg;

    // bin and power widths
    localparam int BIN_W   = 24;
    localparam int SQ_W    = 2 * BIN_W - 1;   // square of a signed 24-bit value
    localparam int POWER_W = SQ_W + 1;        // sum of two squares
    localparam int MSB_W   = $clog2(POWER_W);
    localparam int FRAC_W  = 5;

    // dB arithmetic, signed Q8.8
    localparam int LEVEL_W  = 17;
    localparam int RAW_W    = LEVEL_W + 1;
    localparam int WHOLE_W  = 16;
    localparam int SMOOTH_W = 16;
    localparam int WEIGHT_W = SMOOTH_W + 1;
    localparam int ACC_W    = 36;
    localparam int Q_SHIFT  = 16;
    localparam int AVG_W    = ACC_W - Q_SHIFT;

    localparam logic [31:0]                DB_PER_OCT = 32'd197284;  // 10*log10(2), Q16
    localparam logic signed [RAW_W-1:0]    FLOOR_DB   = -18'sd51200; // -200 dB
    localparam logic signed [LEVEL_W-1:0]  LEVEL_MIN  = -17'sd65536;
    localparam logic signed [LEVEL_W-1:0]  LEVEL_MAX  = 17'sd65535;
    localparam logic signed [ACC_W-1:0]    ROUND_HALF = 36'sd32768;
    localparam logic [WEIGHT_W-1:0]        Q16_ONE    = 17'h10000;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = LEVEL_W;

    localparam logic [SMOOTH_W-1:0]       SMOOTH_RST = 16'd65470;
    localparam logic signed [LEVEL_W-1:0] OFFSET_RST = -17'sd30822;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SMOOTH = 1'b0,
        REG_OFFSET = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [SMOOTH_W-1:0]       smooth;
        logic signed [LEVEL_W-1:0] offset;
    } t_cfg_regs;

    // round(256*10*log10(1+k/32))
    localparam logic [9:0] FRAC_DB [32] = '{
        10'd0,   10'd34,  10'd67,  10'd100, 10'd131, 10'd161, 10'd191, 10'd220,
        10'd248, 10'd276, 10'd302, 10'd328, 10'd354, 10'd379, 10'd403, 10'd427,
        10'd451, 10'd474, 10'd496, 10'd518, 10'd540, 10'd561, 10'd582, 10'd602,
        10'd622, 10'd642, 10'd661, 10'd680, 10'd699, 10'd717, 10'd735, 10'd753
    };

    // octave part of the log: (p*197284 + 128) >> 8
    function automatic logic [WHOLE_W-1:0] db_whole(input logic [MSB_W-1:0] p);
        logic [31:0] prod;
        prod = 32'(p) * DB_PER_OCT + 32'd128;
        return prod[WHOLE_W+7:8];
    endfunction

endpackage

>>> sv/spa_if.sv
// Channel interfaces: FFT bin input, averaged level output, register writes.
// Depends on spa_pkg.
interface spa_bin_if #(parameter int IDX_W = 10);
    import spa_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        bin_index;
    logic signed [BIN_W-1:0] bin_real;
    logic signed [BIN_W-1:0] bin_imag;
    modport source (output valid, bin_index, bin_real, bin_imag, input ready);
    modport sink   (input valid, bin_index, bin_real, bin_imag, output ready);
endinterface

interface spa_lvl_if #(parameter int IDX_W = 10);
    import spa_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [IDX_W-1:0]          display_index;
    logic signed [LEVEL_W-1:0] level_db;
    modport source (output valid, display_index, level_db, input ready);
    modport sink   (input valid, display_index, level_db, output ready);
endinterface

interface spa_cfg_if;
    import spa_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/spa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read during write to the same address returns the old contents.
module spa_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/spa_cfg_regs.sv
// Configuration registers: smoothing weight and dB offset.
// Depends on spa_pkg and spa_cfg_if.
module spa_cfg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    spa_cfg_if.sink            i_cfg,
    output spa_pkg::t_cfg_regs o_regs
);
    import spa_pkg::*;

    t_cfg_regs r_regs;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.smooth <= SMOOTH_RST;
            r_regs.offset <= OFFSET_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.index))
                REG_SMOOTH: r_regs.smooth <= i_cfg.data[SMOOTH_W-1:0];
                REG_OFFSET: r_regs.offset <= $signed(i_cfg.data[LEVEL_W-1:0]);
                default: ;
            endcase
        end
    end

    assign o_regs = r_regs;
endmodule

>>> sv/spa_db_front.sv
// Front end, four stages: FFT shift and squares, power sum, leading-one
// detect, log table and offset. Depends on spa_pkg.
module spa_db_front #(
    parameter int IDX_W = 10
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic [IDX_W-1:0]                     i_bin_index,
    input  logic signed [spa_pkg::BIN_W-1:0]     i_bin_real,
    input  logic signed [spa_pkg::BIN_W-1:0]     i_bin_imag,
    input  logic signed [spa_pkg::LEVEL_W-1:0]   i_db_offset,
    input  logic                                 i_load_next,
    output logic                                 o_load_a,
    output logic                                 o_valid,
    output logic [IDX_W-1:0]                     o_pos,
    output logic signed [spa_pkg::RAW_W-1:0]     o_raw
);
    import spa_pkg::*;

    localparam logic [IDX_W-1:0] HALF = {1'b1, {(IDX_W-1){1'b0}}};

    logic load_a, load_b, load_c, load_d;

    // stage A
    logic                      r_a_valid;
    logic [IDX_W-1:0]          r_a_pos;
    logic [SQ_W-1:0]           r_a_sq_re, r_a_sq_im;
    logic signed [2*BIN_W-1:0] n_sq_re, n_sq_im;
    // stage B
    logic                      r_b_valid;
    logic [IDX_W-1:0]          r_b_pos;
    logic [POWER_W-1:0]        r_b_power, n_power;
    // stage C
    logic                      r_c_valid;
    logic [IDX_W-1:0]          r_c_pos;
    logic [POWER_W-1:0]        r_c_power;
    logic [MSB_W-1:0]          r_c_msb, n_msb;
    logic                      r_c_zero, n_zero;
    // stage D
    logic                      r_d_valid;
    logic [IDX_W-1:0]          r_d_pos;
    logic signed [RAW_W-1:0]   r_d_raw, n_raw;
    logic [POWER_W+FRAC_W-1:0] n_shifted;
    logic [FRAC_W-1:0]         n_frac_k;

    // a stage loads when it is empty or its word moves on
    assign load_d = !r_d_valid || i_load_next;
    assign load_c = !r_c_valid || load_d;
    assign load_b = !r_b_valid || load_c;
    assign load_a = !r_a_valid || load_b;

    assign n_sq_re = i_bin_real * i_bin_real;
    assign n_sq_im = i_bin_imag * i_bin_imag;
    assign n_power = {1'b0, r_a_sq_re} + {1'b0, r_a_sq_im};

    always_comb begin
        n_msb = '0;
        for (int i = 1; i < POWER_W; i++) begin
            if (r_b_power[i]) begin
                n_msb = MSB_W'(i);
            end
        end
    end
    assign n_zero = (r_b_power == '0);

    // five bits just below the leading one, zero filled from below
    assign n_shifted = {r_c_power, {FRAC_W{1'b0}}} >> r_c_msb;
    assign n_frac_k  = n_shifted[FRAC_W-1:0];

    always_comb begin
        if (r_c_zero) begin
            n_raw = FLOOR_DB;
        end else begin
            n_raw = $signed(RAW_W'(db_whole(r_c_msb))) + $signed(RAW_W'(FRAC_DB[n_frac_k]))
                  + RAW_W'(i_db_offset);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (load_a) r_a_valid <= i_valid;
            if (load_b) r_b_valid <= r_a_valid;
            if (load_c) r_c_valid <= r_b_valid;
            if (load_d) r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_a) begin
            r_a_pos   <= i_bin_index ^ HALF;
            r_a_sq_re <= n_sq_re[SQ_W-1:0];
            r_a_sq_im <= n_sq_im[SQ_W-1:0];
        end
        if (load_b) begin
            r_b_pos   <= r_a_pos;
            r_b_power <= n_power;
        end
        if (load_c) begin
            r_c_pos   <= r_b_pos;
            r_c_power <= r_b_power;
            r_c_msb   <= n_msb;
            r_c_zero  <= n_zero;
        end
        if (load_d) begin
            r_d_pos <= r_c_pos;
            r_d_raw <= n_raw;
        end
    end

    assign o_load_a = load_a;
    assign o_valid  = r_d_valid;
    assign o_pos    = r_d_pos;
    assign o_raw    = r_d_raw;
endmodule

>>> sv/spa_avg_update.sv
// Averaging back end: weighted new term, read-modify-write of the average
// store with bypass, saturation, output register, clear pass after reset.
// Depends on spa_pkg and spa_ram.
module spa_avg_update #(
    parameter int IDX_W = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [spa_pkg::SMOOTH_W-1:0]        i_smooth,
    input  logic                                i_valid,
    input  logic [IDX_W-1:0]                    i_pos,
    input  logic signed [spa_pkg::RAW_W-1:0]    i_raw,
    input  logic                                i_out_ready,
    output logic                                o_load_e,
    output logic                                o_clearing,
    output logic                                o_valid,
    output logic [IDX_W-1:0]                    o_pos,
    output logic signed [spa_pkg::LEVEL_W-1:0]  o_level
);
    import spa_pkg::*;

    logic load_e, load_f;

    logic                       r_clearing;
    logic [IDX_W-1:0]           r_clr_addr;

    logic                       r_e_valid;
    logic [IDX_W-1:0]           r_e_pos;
    logic signed [ACC_W-1:0]    r_e_prod, n_e_prod, n_new_prod;

    logic                       r_f_valid;
    logic [IDX_W-1:0]           r_f_pos;
    logic signed [LEVEL_W-1:0]  r_f_level, n_level;

    logic [WEIGHT_W-1:0]        weight;
    logic signed [LEVEL_W-1:0]  old_avg, ram_rdata;
    logic signed [ACC_W-1:0]    n_old_prod, n_acc;
    logic signed [AVG_W-1:0]    n_avg_wide;

    logic                       ram_we;
    logic [IDX_W-1:0]           ram_waddr, ram_raddr;
    logic [LEVEL_W-1:0]         ram_wdata, ram_rword;

    assign load_f = !r_f_valid || i_out_ready;
    assign load_e = !r_e_valid || load_f;

    // new term weighted by 1 - s, with the rounding half folded in
    assign weight     = Q16_ONE - {1'b0, i_smooth};
    assign n_new_prod = i_raw * $signed({1'b0, weight});
    assign n_e_prod   = n_new_prod + ROUND_HALF;

    // the word one stage ahead may target the same position
    assign old_avg    = (r_f_valid && r_f_pos == r_e_pos) ? r_f_level : ram_rdata;
    assign n_old_prod = old_avg * $signed({1'b0, i_smooth});
    assign n_acc      = r_e_prod + n_old_prod;
    assign n_avg_wide = n_acc[ACC_W-1:Q_SHIFT];

    always_comb begin
        if (n_avg_wide < AVG_W'(LEVEL_MIN)) begin
            n_level = LEVEL_MIN;
        end else if (n_avg_wide > AVG_W'(LEVEL_MAX)) begin
            n_level = LEVEL_MAX;
        end else begin
            n_level = n_avg_wide[LEVEL_W-1:0];
        end
    end

    // read is issued as a word enters stage E and repeated while it waits
    assign ram_raddr = load_e ? i_pos : r_e_pos;
    assign ram_we    = r_clearing || (load_f && r_e_valid);
    assign ram_waddr = r_clearing ? r_clr_addr : r_e_pos;
    assign ram_wdata = r_clearing ? '0 : n_level;
    assign ram_rdata = $signed(ram_rword);

    spa_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (2 ** IDX_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rword)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_e_valid  <= 1'b0;
            r_f_valid  <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    r_clearing <= 1'b0;
                end
            end
            if (load_e) r_e_valid <= i_valid;
            if (load_f) r_f_valid <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_e) begin
            r_e_pos  <= i_pos;
            r_e_prod <= n_e_prod;
        end
        if (load_f) begin
            r_f_pos   <= r_e_pos;
            r_f_level <= n_level;
        end
    end

    assign o_load_e   = load_e;
    assign o_clearing = r_clearing;
    assign o_valid    = r_f_valid;
    assign o_pos      = r_f_pos;
    assign o_level    = r_f_level;

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !r_e_valid && !r_f_valid)
        else $error("word in back end during clear pass");

    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_clearing |=> !r_clearing)
        else $error("clear pass restarted");

    a_clear_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clearing) |-> r_clr_addr == '0 && $past(r_clr_addr) == '1)
        else $error("clear pass ended early");

    a_e_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_valid && !load_e |=> r_e_valid && $stable(r_e_pos) && $stable(r_e_prod))
        else $error("stage E word changed while stalled");
endmodule

>>> sv/spectrum_power_db_averager.sv
// Top level of the spectrum power dB averager.
// Depends on spa_pkg, spa_if, spa_cfg_regs, spa_db_front, spa_avg_update.
//
//   port     dir   payload                              word moves when
//   i_bin    in    bin_index, bin_real, bin_imag        valid && ready
//   o_level  out   display_index, level_db              valid && ready
//   i_cfg    in    index, data                          valid && ready
//
// One bin word per clock while o_level is not held; a word passes six register stages,
// A to F, on its way from i_bin to o_level.
// After reset the average store is swept to zero at every position, with i_bin.ready low.
// Each stage holds a valid bit; a held o_level stalls only the stages that are full,
// so empty stages keep filling and i_bin.ready stays high until the pipe is packed.
// Averages at one position chain through the store with a bypass from the output word.
module spectrum_power_db_averager #(
    parameter int BINS = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spa_cfg_if.sink    i_cfg,
    spa_bin_if.sink    i_bin,
    spa_lvl_if.source  o_level
);
    import spa_pkg::*;

    localparam int IDX_W = $clog2(BINS);

    t_cfg_regs               cfg_regs;
    logic                    load_a, load_e, clearing;
    logic                    d_valid;
    logic [IDX_W-1:0]        d_pos;
    logic signed [RAW_W-1:0] d_raw;

    spa_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_regs  (cfg_regs)
    );

    assign i_bin.ready = load_a && !clearing;

    spa_db_front #(
        .IDX_W (IDX_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_bin.valid && !clearing),
        .i_bin_index (i_bin.bin_index),
        .i_bin_real  (i_bin.bin_real),
        .i_bin_imag  (i_bin.bin_imag),
        .i_db_offset (cfg_regs.offset),
        .i_load_next (load_e),
        .o_load_a    (load_a),
        .o_valid     (d_valid),
        .o_pos       (d_pos),
        .o_raw       (d_raw)
    );

    spa_avg_update #(
        .IDX_W (IDX_W)
    ) u_avg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_smooth    (cfg_regs.smooth),
        .i_valid     (d_valid),
        .i_pos       (d_pos),
        .i_raw       (d_raw),
        .i_out_ready (o_level.ready),
        .o_load_e    (load_e),
        .o_clearing  (clearing),
        .o_valid     (o_level.valid),
        .o_pos       (o_level.display_index),
        .o_level     (o_level.level_db)
    );
endmodule
